FILE: design/bsc_pkg.sv
// Package for the barometric sensor compensation block.
// Holds the sequencer step type, the command and status structs and the constants.
// No dependencies.
`default_nettype none
package bsc_pkg;

    localparam int NUM_CAL = 5;

    localparam logic [2:0] CAL_PT = 3'd0;
    localparam logic [2:0] CAL_SC = 3'd1;
    localparam logic [2:0] CAL_TG = 3'd2;
    localparam logic [2:0] CAL_QB = 3'd3;
    localparam logic [2:0] CAL_TN = 3'd4;

    localparam logic [31:0] CAL_RESET [NUM_CAL] = '{
        32'd26804152, 32'd3352395749, 32'd2146785905, 32'd405667844, 32'd3724086068
    };

    localparam logic [31:0] TERM_OFS = 32'd4000;
    localparam logic [31:0] B4_BIAS  = 32'd32768;
    localparam logic [31:0] P_SCALE  = 32'd50000;
    localparam logic [31:0] C_SQ     = 32'd3038;
    localparam logic [31:0] C_LIN    = 32'hFFFF_E343;
    localparam logic [31:0] C_OFS    = 32'd3791;
    // Reciprocal of 100 scaled by 2**38, rounded up; exact for magnitudes up to 2**31.
    localparam logic [31:0] HPA_RCP  = 32'd2748779070;

    typedef logic [31:0] t_cal [NUM_CAL];

    typedef enum logic [5:0] {
        ST_IDLE,
        T_MUL1, T_X1, T_DEN, T_DIV, T_B5,
        P_B6, P_M1, P_SQ, P_M2, P_X1, P_M3, P_X3, P_B3, P_M4, P_X1B, P_M5, P_X3B,
        P_M6, P_B4, P_M7, P_B7, P_DIV, P_P, P_M8, P_M9, P_X1C, P_M10, P_PF,
        P_HLD, P_HPA,
        ST_FIN
    } t_state;

    typedef struct packed {
        t_state step;
        logic   capture;
        logic   load_out;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic den_zero;
        logic b4_zero;
    } t_sts;

    function automatic logic [31:0] asr32(logic [31:0] v, logic [4:0] s);
        return 32'($signed(v) >>> s);
    endfunction

    function automatic logic [31:0] abs32(logic [31:0] v);
        return v[31] ? 32'(-v) : v;
    endfunction

    function automatic logic [31:0] sx16(logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

endpackage
`default_nettype wire

FILE: design/bsc_ctrl.sv
// Sequencer of the compensation block: walks the arithmetic steps of one request.
// Depends on bsc_pkg; drives the datapath bsc_dp through a command struct.
`default_nettype none
module bsc_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_in_mode,
    input  wire logic          i_out_ready,
    input  wire bsc_pkg::t_sts i_sts,
    output bsc_pkg::t_cmd      o_cmd,
    output logic               o_in_ready,
    output logic               o_out_valid
);
    import bsc_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state          = r_state;
        o_cmd.step       = r_state;
        o_cmd.capture    = 1'b0;
        o_cmd.load_out   = 1'b0;
        o_in_ready       = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = i_in_mode ? P_B6 : T_MUL1;
                end
            end
            T_MUL1: n_state = T_X1;
            T_X1:   n_state = T_DEN;
            T_DEN:  n_state = i_sts.den_zero ? ST_FIN : T_DIV;
            T_DIV:  if (i_sts.div_done) n_state = T_B5;
            T_B5:   n_state = ST_FIN;
            P_B6:   n_state = P_M1;
            P_M1:   n_state = P_SQ;
            P_SQ:   n_state = P_M2;
            P_M2:   n_state = P_X1;
            P_X1:   n_state = P_M3;
            P_M3:   n_state = P_X3;
            P_X3:   n_state = P_B3;
            P_B3:   n_state = P_M4;
            P_M4:   n_state = P_X1B;
            P_X1B:  n_state = P_M5;
            P_M5:   n_state = P_X3B;
            P_X3B:  n_state = P_M6;
            P_M6:   n_state = P_B4;
            P_B4:   n_state = P_M7;
            P_M7:   n_state = P_B7;
            P_B7:   n_state = i_sts.b4_zero ? ST_FIN : P_DIV;
            P_DIV:  if (i_sts.div_done) n_state = P_P;
            P_P:    n_state = P_M8;
            P_M8:   n_state = P_M9;
            P_M9:   n_state = P_X1C;
            P_X1C:  n_state = P_M10;
            P_M10:  n_state = P_PF;
            P_PF:   n_state = P_HLD;
            P_HLD:  n_state = P_HPA;
            P_HPA:  n_state = ST_FIN;
            ST_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        n_out_valid = o_cmd.load_out ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);
    end

    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

FILE: design/bsc_dp.sv
// Datapath of the compensation block: one 32x32 multiplier, a bit-serial divider,
// the working registers and the result register. Depends on bsc_pkg.
`default_nettype none
module bsc_dp (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire bsc_pkg::t_cmd   i_cmd,
    input  wire bsc_pkg::t_cal   i_cal,
    input  wire logic            i_mode,
    input  wire logic [23:0]     i_raw,
    output bsc_pkg::t_sts        o_sts,
    output logic                 o_kind,
    output logic [31:0]          o_temp,
    output logic [31:0]          o_pa,
    output logic [25:0]          o_hpa,
    output logic                 o_err
);
    import bsc_pkg::*;

    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic        r_mode, r_err, r_shl, r_neg;
    logic [23:0] r_raw;
    logic [31:0] r_mul, r_x1, r_b6, r_sq, r_b3, r_b4, r_p, r_term, r_temp;
    logic [25:0] r_hpa, r_hq;
    logic [31:0] r_dq, r_dvs;
    logic [32:0] r_rem;
    logic [4:0]  r_cnt;
    logic [31:0] op_a, op_b, den, num, q_s, b5, pu;
    logic [63:0] prod;
    logic        mul_en, div_ld, div_run, ld_neg;
    logic [31:0] ld_a, ld_b;
    logic [32:0] rem_sh, rem_sub;

    assign ac1 = sx16(i_cal[CAL_PT][31:16]);
    assign ac2 = sx16(i_cal[CAL_PT][15:0]);
    assign ac3 = sx16(i_cal[CAL_SC][31:16]);
    assign ac4 = {16'd0, i_cal[CAL_SC][15:0]};
    assign ac5 = {16'd0, i_cal[CAL_TG][31:16]};
    assign ac6 = {16'd0, i_cal[CAL_TG][15:0]};
    assign b1  = sx16(i_cal[CAL_QB][31:16]);
    assign b2  = sx16(i_cal[CAL_QB][15:0]);
    assign mc  = sx16(i_cal[CAL_TN][31:16]);
    assign md  = sx16(i_cal[CAL_TN][15:0]);

    assign den = r_x1 + md;
    assign num = {mc[20:0], 11'd0};
    assign pu  = {8'd0, r_raw[23:8]};
    assign q_s = r_neg ? 32'(-r_dq) : r_dq;
    assign b5  = r_x1 + q_s;
    assign prod = op_a * op_b;

    assign div_run = (i_cmd.step == T_DIV) || (i_cmd.step == P_DIV);
    assign rem_sh  = {r_rem[31:0], r_dq[31]};
    assign rem_sub = rem_sh - {1'b0, r_dvs};

    always_comb begin
        mul_en = 1'b1;
        op_a   = '0;
        op_b   = '0;
        unique case (i_cmd.step)
            T_MUL1: begin op_a = {16'd0, r_raw[15:0]} - ac6; op_b = ac5; end
            P_M1:   begin op_a = r_b6; op_b = r_b6; end
            P_M2:   begin op_a = b2; op_b = r_sq; end
            P_M3:   begin op_a = ac2; op_b = r_b6; end
            P_M4:   begin op_a = ac3; op_b = r_b6; end
            P_M5:   begin op_a = b1; op_b = r_sq; end
            P_M6:   begin op_a = ac4; op_b = r_x1 + B4_BIAS; end
            P_M7:   begin op_a = pu - r_b3; op_b = P_SCALE; end
            P_M8:   begin op_a = asr32(r_p, 5'd8); op_b = asr32(r_p, 5'd8); end
            P_M9:   begin op_a = r_mul; op_b = C_SQ; end
            P_M10:  begin op_a = C_LIN; op_b = r_p; end
            P_HLD:  begin op_a = abs32(r_p); op_b = HPA_RCP; end
            default: mul_en = 1'b0;
        endcase
    end

    always_comb begin
        div_ld = 1'b1;
        ld_a   = '0;
        ld_b   = '0;
        ld_neg = 1'b0;
        unique case (i_cmd.step)
            T_DEN: begin ld_a = abs32(num); ld_b = abs32(den); ld_neg = num[31] ^ den[31]; end
            P_B7:  begin ld_a = r_mul[31] ? r_mul : {r_mul[30:0], 1'b0}; ld_b = r_b4; end
            default: div_ld = 1'b0;
        endcase
    end

    assign o_sts.div_done = div_run && (r_cnt == 5'd31);
    assign o_sts.den_zero = (den == 32'd0);
    assign o_sts.b4_zero  = (r_b4 == 32'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term <= '0;
        end else if (i_cmd.step == T_B5) begin
            r_term <= b5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mul_en) r_mul <= prod[31:0];
        if (div_ld) begin
            r_dq  <= ld_a;
            r_dvs <= ld_b;
            r_neg <= ld_neg;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (div_run) begin
            r_cnt <= r_cnt + 5'd1;
            if (!rem_sub[32]) begin
                r_rem <= rem_sub;
                r_dq  <= {r_dq[30:0], 1'b1};
            end else begin
                r_rem <= rem_sh;
                r_dq  <= {r_dq[30:0], 1'b0};
            end
        end
        if (i_cmd.capture) begin
            r_mode <= i_mode;
            r_raw  <= i_raw;
            r_err  <= 1'b0;
        end
        unique case (i_cmd.step)
            T_X1:  r_x1 <= asr32(r_mul, 5'd15);
            T_DEN: r_err <= (den == 32'd0);
            T_B5:  r_temp <= asr32(b5 + 32'd8, 5'd4);
            P_B6:  r_b6 <= r_term - TERM_OFS;
            P_SQ:  r_sq <= asr32(r_mul, 5'd12);
            P_X1:  r_x1 <= asr32(r_mul, 5'd11);
            P_X3:  r_x1 <= r_x1 + asr32(r_mul, 5'd11);
            P_B3:  r_b3 <= asr32({ac1[29:0], 2'd0} + r_x1 + 32'd2, 5'd2);
            P_X1B: r_x1 <= asr32(r_mul, 5'd13);
            P_X3B: r_x1 <= asr32(r_x1 + asr32(r_mul, 5'd16) + 32'd2, 5'd2);
            P_B4:  r_b4 <= {15'd0, r_mul[31:15]};
            P_B7:  begin r_err <= (r_b4 == 32'd0); r_shl <= r_mul[31]; end
            P_P:   r_p <= r_shl ? {r_dq[30:0], 1'b0} : r_dq;
            P_X1C: r_x1 <= asr32(r_mul, 5'd16);
            P_PF:  r_p <= r_p + asr32(r_x1 + asr32(r_mul, 5'd16) + C_OFS, 5'd4);
            P_HLD: r_hq <= prod[63:38];
            P_HPA: r_hpa <= r_p[31] ? 26'(-r_hq) : r_hq;
            default: ;
        endcase
        if (i_cmd.load_out) begin
            o_kind <= r_mode;
            o_err  <= r_err;
            o_temp <= (!r_mode && !r_err) ? r_temp : 32'd0;
            o_pa   <= (r_mode && !r_err) ? r_p : 32'd0;
            o_hpa  <= (r_mode && !r_err) ? r_hpa : 26'd0;
        end
    end

endmodule
`default_nettype wire

FILE: design/barometric_sensor_compensation.sv
// Barometric sensor compensation: five calibration registers on the APB-style port,
// input and result streams, sequencer bsc_ctrl and datapath bsc_dp. Depends on bsc_pkg.
//
// A request on the slave stream carries one raw reading in tdata and its mode in
// tuser (0 temperature, 1 pressure). Each request yields one result on the master
// stream: tuser holds the kind and the divide error flag, tdata the temperature in
// tenths of a degree, the pressure in pascal and in whole hectopascal.
// A temperature request stores its intermediate term for later pressure requests.
// Requests are handled one at a time; a new one is accepted only after the last is done.
// A zero divisor ends a temperature or pressure request early, before its divide step.
// Each request makes at most one divider pass and uses the shared multiplier that
// takes one product per cycle; the hectopascal value comes from a reciprocal product.
// The next request is accepted as soon as the previous one has moved into the result
// register, so a stalled receiver holds only the finished result while the next
// request is computed; the sequencer then waits until the result register is free.
// Reset is synchronous and active low: it loads the factory calibration values,
// clears the stored temperature term and empties the result register.
`default_nettype none
module barometric_sensor_compensation (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [23:0] i_s_tdata,   // [23:0] raw_reading
    input  wire logic        i_s_tuser,   // [0] mode
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [95:0]      o_m_tdata,   // [31:0] temperature_tenths, [63:32] pressure_pascal,
                                          // [89:64] pressure_hectopascal, [95:90] zero
    output logic [1:0]       o_m_tuser,   // [0] result_kind, [1] divide_error
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import bsc_pkg::*;

    t_cal        r_cal;
    t_cmd        cmd;
    t_sts        sts;
    logic [2:0]  reg_idx;
    logic        kind, err;
    logic [31:0] temp, pa;
    logic [25:0] hpa;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= CAL_RESET;
        end else if (psel && penable && pwrite && (reg_idx < 3'(NUM_CAL))) begin
            r_cal[reg_idx] <= pwdata;
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_idx < 3'(NUM_CAL)) prdata = r_cal[reg_idx];
    end

    bsc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .i_in_mode   (i_s_tuser),
        .i_out_ready (i_m_tready),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_ready  (o_s_tready),
        .o_out_valid (o_m_tvalid)
    );

    bsc_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_cal   (r_cal),
        .i_mode  (i_s_tuser),
        .i_raw   (i_s_tdata),
        .o_sts   (sts),
        .o_kind  (kind),
        .o_temp  (temp),
        .o_pa    (pa),
        .o_hpa   (hpa),
        .o_err   (err)
    );

    assign o_m_tdata = {6'd0, hpa, pa, temp};
    assign o_m_tuser = {err, kind};

`ifndef ASSERT_OFF
    a_temp_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[0]) |-> (pa == 32'd0 && hpa == 26'd0))
        else $error("temperature result carries pressure values");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[1]) |-> (temp == 32'd0 && pa == 32'd0 && hpa == 26'd0))
        else $error("divide error result carries nonzero values");

    a_hpa_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && hpa != 26'd0) |-> (hpa[25] == pa[31]))
        else $error("hectopascal sign differs from pascal sign");
`endif

endmodule
`default_nettype wire
